/* src/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// Shared widths, codes and controller/datapath command type for the sorted
// multiset table unit.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int ENTRIES     = 64;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 16;
   localparam int MULT_BITS   = 16;
   localparam int TOTAL_BITS  = 32;
   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 2;

   localparam int USED_BITS = $clog2(ENTRIES + 1);
   localparam int SUM_BITS  = ((COUNT_BITS > MULT_BITS) ? COUNT_BITS : MULT_BITS) + 1;

   localparam int REQ_BITS      = ACTION_BITS + VALUE_BITS + MULT_BITS;
   localparam int REQ_DATA_BITS = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_PRESENT_BIT  = STATUS_BITS;
   localparam int RSP_SMALLEST_LSB = STATUS_BITS + 1;
   localparam int RSP_SVALID_BIT   = RSP_SMALLEST_LSB + VALUE_BITS;
   localparam int RSP_EMPTY_BIT    = RSP_SVALID_BIT + 1;
   localparam int RSP_TOTAL_LSB    = RSP_EMPTY_BIT + 1;
   localparam int RSP_BITS         = RSP_TOTAL_LSB + TOTAL_BITS;
   localparam int RSP_DATA_BITS    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_ABSENT    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_SATURATED = 2'd3;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic        [COUNT_BITS-1:0] count_type;
   typedef logic        [TOTAL_BITS-1:0] total_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } dp_cmd_type;

endpackage

/* src/sms_ctrl.sv */
// ----------------------------------------------------------------------------
// sms_ctrl
// Sequencer: accepts an item, runs the compare step, then the update step,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module sms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output sms_pkg::dp_cmd_type cmd_out
);
   import sms_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_commit;
   logic       accept;

   assign can_commit = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_UPD) && can_commit);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd_out.load    = accept;
      cmd_out.compare = (state_ff == S_CMP);
      cmd_out.commit  = (state_ff == S_UPD) && can_commit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (can_commit) state_in = accept ? S_CMP : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd_out.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/sms_dpath.sv */
// ----------------------------------------------------------------------------
// sms_dpath
// Row of sorted entry cells with parallel compare flags, shift-in/shift-out
// update, occurrence total and result register.
// ----------------------------------------------------------------------------
module sms_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  sms_pkg::dp_cmd_type                cmd_in,
   input  logic [sms_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic [sms_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import sms_pkg::*;

   localparam logic [SUM_BITS-1:0] CNT_MAX_S =
      {{(SUM_BITS - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

   logic [ACTION_BITS-1:0] act_ff;
   value_type              val_ff;
   logic [MULT_BITS-1:0]   mult_ff;

   value_type cell_val_ff [ENTRIES];
   value_type cell_val_in [ENTRIES];
   count_type cell_cnt_ff [ENTRIES];
   count_type cell_cnt_in [ENTRIES];

   logic [ENTRIES-1:0] lt_ff, lt_in, eq_ff, eq_in;

   logic [USED_BITS-1:0] used_ff, used_in;
   total_type            total_ff, total_in;

   logic [RSP_DATA_BITS-1:0] rsp_ff;

   logic                is_ins, is_rem, mult_nz, found, full;
   count_type           hit_cnt;
   logic [SUM_BITS-1:0] hit_sum, hit_add, new_cnt_w, add;
   logic                hit_clip, new_clip, tot_clip;
   count_type           hit_new_cnt;
   logic                do_bump, do_open, do_dec, do_drop;
   logic [TOTAL_BITS:0] tot_sum;
   logic [STATUS_BITS-1:0] status;
   logic                present;

   // request
   always_ff @(posedge clock) begin
      if (cmd_in.load) begin
         act_ff  <= req_tdata[ACTION_BITS-1:0];
         val_ff  <= req_tdata[ACTION_BITS +: VALUE_BITS];
         mult_ff <= req_tdata[ACTION_BITS + VALUE_BITS +: MULT_BITS];
      end
   end

   // compare step: all live cells at once
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         lt_in[i] = (USED_BITS'(i) < used_ff) && (cell_val_ff[i] < val_ff);
         eq_in[i] = (USED_BITS'(i) < used_ff) && (cell_val_ff[i] == val_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   // update step
   always_comb begin
      hit_cnt = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_cnt = hit_cnt | (eq_ff[i] ? cell_cnt_ff[i] : '0);
      end
   end

   always_comb begin
      is_ins  = (act_ff == ACT_INSERT);
      is_rem  = (act_ff == ACT_REMOVE);
      mult_nz = (mult_ff != '0);
      found   = |eq_ff;
      full    = (used_ff == USED_BITS'(ENTRIES));

      hit_sum     = SUM_BITS'(hit_cnt) + SUM_BITS'(mult_ff);
      hit_clip    = hit_sum > CNT_MAX_S;
      hit_add     = hit_clip ? (CNT_MAX_S - SUM_BITS'(hit_cnt)) : SUM_BITS'(mult_ff);
      hit_new_cnt = hit_clip ? '1 : hit_sum[COUNT_BITS-1:0];

      new_clip  = SUM_BITS'(mult_ff) > CNT_MAX_S;
      new_cnt_w = new_clip ? CNT_MAX_S : SUM_BITS'(mult_ff);

      do_bump = is_ins && mult_nz && found;
      do_open = is_ins && mult_nz && !found && !full;
      do_dec  = is_rem && found && (hit_cnt > count_type'(1));
      do_drop = is_rem && found && !(hit_cnt > count_type'(1));

      add      = do_bump ? hit_add : (do_open ? new_cnt_w : '0);
      tot_sum  = (TOTAL_BITS + 1)'(total_ff) + (TOTAL_BITS + 1)'(add);
      tot_clip = tot_sum[TOTAL_BITS];

      status = ST_DONE;
      priority if (is_ins) begin
         if (mult_nz) begin
            if (found) status = (hit_clip || tot_clip) ? ST_SATURATED : ST_DONE;
            else if (full) status = ST_FULL;
            else status = (new_clip || tot_clip) ? ST_SATURATED : ST_DONE;
         end
      end else begin
         status = found ? ST_DONE : ST_ABSENT;
      end

      present = found ? !do_drop : do_open;
   end

   always_comb begin
      total_in = total_ff;
      used_in  = used_ff;
      if (cmd_in.commit) begin
         if (do_bump || do_open) begin
            total_in = tot_clip ? '1 : tot_sum[TOTAL_BITS-1:0];
         end else if ((do_dec || do_drop) && (total_ff != '0)) begin
            total_in = total_ff - 1'b1;
         end
         if (do_open) used_in = used_ff + 1'b1;
         else if (do_drop) used_in = used_ff - 1'b1;
      end
   end

   // cell row
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         cell_val_in[i] = cell_val_ff[i];
         cell_cnt_in[i] = cell_cnt_ff[i];
         if (cmd_in.commit) begin
            if (do_open && !lt_ff[i]) begin
               if (i == 0) begin
                  cell_val_in[i] = val_ff;
                  cell_cnt_in[i] = new_cnt_w[COUNT_BITS-1:0];
               end else if (lt_ff[(i == 0) ? 0 : i - 1]) begin
                  cell_val_in[i] = val_ff;
                  cell_cnt_in[i] = new_cnt_w[COUNT_BITS-1:0];
               end else begin
                  cell_val_in[i] = cell_val_ff[(i == 0) ? 0 : i - 1];
                  cell_cnt_in[i] = cell_cnt_ff[(i == 0) ? 0 : i - 1];
               end
            end else if (do_drop && !lt_ff[i]) begin
               if (i < ENTRIES - 1) begin
                  cell_val_in[i] = cell_val_ff[(i < ENTRIES - 1) ? i + 1 : i];
                  cell_cnt_in[i] = cell_cnt_ff[(i < ENTRIES - 1) ? i + 1 : i];
               end
            end else if (eq_ff[i] && do_bump) begin
               cell_cnt_in[i] = hit_new_cnt;
            end else if (eq_ff[i] && do_dec) begin
               cell_cnt_in[i] = cell_cnt_ff[i] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         cell_val_ff[i] <= cell_val_in[i];
         cell_cnt_ff[i] <= cell_cnt_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         total_ff <= '0;
      end else begin
         used_ff  <= used_in;
         total_ff <= total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd_in.commit) begin
         rsp_ff <= RSP_DATA_BITS'({total_in,
                                   (total_in == '0),
                                   (used_in != '0),
                                   ((used_in != '0) ? cell_val_in[0] : value_type'(0)),
                                   present,
                                   status});
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

/* src/sorted_multiset_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_multiset_table_unit
// Multiset of signed values held as an ascending table of distinct values with
// saturating occurrence counts and a saturating total. Insert, remove or query
// one item at a time.
// ----------------------------------------------------------------------------
// An item passes through a compare step, in which every cell of the entry row
// compares its value against the item, and then an update step, in which the
// row shifts or updates a count and the result register loads; the update step
// waits while an earlier result is held undrained. A new item is taken in the
// same cycle as the previous result loads, as long as the result register is
// free or being drained. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_multiset_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action[1:0], value[33:2], multiplicity[49:34], zero pad
   input  logic [sms_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0], present[2], smallest[34:3], smallest_valid[35],
   // is_empty[36], total[68:37], zero pad
   output logic [sms_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sms_pkg::*;

   dp_cmd_type cmd;

   sms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd_out    (cmd)
   );

   sms_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted during compare step");

   a_result_two_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ##1 (cmd.commit || (rsp_tvalid && !rsp_tready)))
      else $error("update step neither committed nor stalled by result");

   a_smallest_zero_when_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[RSP_SVALID_BIT]) |->
         (rsp_tdata[RSP_SMALLEST_LSB +: VALUE_BITS] == '0))
      else $error("smallest nonzero on empty table");

   a_empty_matches_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[RSP_EMPTY_BIT] == (rsp_tdata[RSP_TOTAL_LSB +: TOTAL_BITS] == '0)))
      else $error("is_empty disagrees with total");

endmodule

/* test/sorted_multiset_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_multiset_table_checker
// Watches both streams of the sorted multiset table unit. For every accepted
// request item it updates its own copy of the value table and queues the
// reply it expects; every accepted reply is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module sorted_multiset_table_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [sms_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [sms_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                pending,
   output int                                failures
);
   import sms_pkg::*;

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_BITS) - 1;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   present;
      value_type              smallest;
      logic                   smallest_valid;
      logic                   is_empty;
      total_type              total;
   } reply_type;

   value_type stored_values[ENTRIES];
   count_type stored_counts[ENTRIES];
   int        used_entries;
   total_type running_total;
   reply_type pending_replies[$];

   // saturating add to the occurrence total, returns 1 on clipping
   function automatic bit add_to_total(longint unsigned amount);
      longint unsigned sum;
      sum = longint'(running_total) + amount;
      if (sum > TOTAL_MAX) begin
         running_total = TOTAL_MAX;
         return 1'b1;
      end
      running_total = total_type'(sum);
      return 1'b0;
   endfunction

   function automatic reply_type apply_item(logic [ACTION_BITS-1:0] action,
                                            value_type value,
                                            logic [MULT_BITS-1:0] mult);
      reply_type       r;
      int              pos;
      int              i;
      bit              found;
      longint unsigned room;
      longint unsigned amount;
      r = '0;
      pos = 0;
      while (pos < used_entries && stored_values[pos] < value)
         pos++;
      found = (pos < used_entries) && (stored_values[pos] == value);
      r.status = ST_DONE;
      r.present = found;
      case (action)
         ACT_INSERT: begin
            if (mult != '0) begin
               if (found) begin
                  room = COUNT_MAX - stored_counts[pos];
                  amount = 64'(mult);
                  if (amount > room) begin
                     amount = room;
                     r.status = ST_SATURATED;
                  end
                  stored_counts[pos] = stored_counts[pos] + count_type'(amount);
                  if (add_to_total(amount))
                     r.status = ST_SATURATED;
               end else if (used_entries >= ENTRIES) begin
                  r.status = ST_FULL;
               end else begin
                  amount = 64'(mult);
                  if (amount > COUNT_MAX) begin
                     amount = COUNT_MAX;
                     r.status = ST_SATURATED;
                  end
                  for (i = used_entries; i > pos; i--) begin
                     stored_values[i] = stored_values[i-1];
                     stored_counts[i] = stored_counts[i-1];
                  end
                  stored_values[pos] = value;
                  stored_counts[pos] = count_type'(amount);
                  used_entries++;
                  if (add_to_total(amount))
                     r.status = ST_SATURATED;
                  r.present = 1'b1;
               end
            end
         end
         ACT_REMOVE: begin
            if (!found) begin
               r.status = ST_ABSENT;
            end else begin
               if (stored_counts[pos] > 1) begin
                  stored_counts[pos] = stored_counts[pos] - 1'b1;
               end else begin
                  for (i = pos; i + 1 < used_entries; i++) begin
                     stored_values[i] = stored_values[i+1];
                     stored_counts[i] = stored_counts[i+1];
                  end
                  used_entries--;
                  r.present = 1'b0;
               end
               if (running_total > 0)
                  running_total = running_total - 1'b1;
            end
         end
         default: begin
            // query, and the spare code behaves as one
            if (!found)
               r.status = ST_ABSENT;
         end
      endcase
      r.smallest = (used_entries > 0) ? stored_values[0] : '0;
      r.smallest_valid = (used_entries > 0);
      r.is_empty = (running_total == 0);
      r.total = running_total;
      return r;
   endfunction

   task automatic compare_field(string field, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         pending_replies.delete();
         used_entries = 0;
         running_total = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[STATUS_BITS-1:0];
            got.present = rsp_tdata[RSP_PRESENT_BIT];
            got.smallest = rsp_tdata[RSP_SMALLEST_LSB +: VALUE_BITS];
            got.smallest_valid = rsp_tdata[RSP_SVALID_BIT];
            got.is_empty = rsp_tdata[RSP_EMPTY_BIT];
            got.total = rsp_tdata[RSP_TOTAL_LSB +: TOTAL_BITS];
            if (pending_replies.size() == 0) begin
               $error("reply item with none expected");
               failures++;
            end else begin
               want = pending_replies.pop_front();
               compare_field("status", longint'(want.status), longint'(got.status));
               compare_field("present", longint'(want.present), longint'(got.present));
               compare_field("smallest", longint'(want.smallest), longint'(got.smallest));
               compare_field("smallest_valid", longint'(want.smallest_valid),
                             longint'(got.smallest_valid));
               compare_field("is_empty", longint'(want.is_empty), longint'(got.is_empty));
               compare_field("total", longint'(want.total), longint'(got.total));
            end
         end
         if (req_tvalid && req_tready)
            pending_replies.push_back(apply_item(
               req_tdata[ACTION_BITS-1:0],
               req_tdata[ACTION_BITS +: VALUE_BITS],
               req_tdata[ACTION_BITS + VALUE_BITS +: MULT_BITS]));
      end
      pending = pending_replies.size();
   end

endmodule

/* test/tb_sorted_multiset_table_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_multiset_table_unit
// Drives insert, remove and query items into the sorted multiset table unit:
// a directed opening on extreme values, counts and absent values, then
// random episodes that mix a few hot values, fill the table past its size
// and drain it again. Sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_table_unit;
   import sms_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;
   localparam value_type VALUE_MIN = value_type'(32'h8000_0000);
   localparam value_type VALUE_MAX = value_type'(32'h7FFF_FFFF);
   localparam int POOL_SIZE    = 96;
   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int        pending;
   int        failures;
   int        cycle_count = 0;
   int        burst_left = 0;
   bit        hold_rsp = 1'b0;
   value_type value_pool[POOL_SIZE];

   always #5 clock = ~clock;

   sorted_multiset_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sorted_multiset_table_checker table_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .failures   (failures)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sorted_multiset_table_unit test failed");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic [ACTION_BITS-1:0] action, value_type value,
                            logic [MULT_BITS-1:0] mult);
      logic [REQ_DATA_BITS-1:0] word;
      int                       gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      word = '0;
      word[ACTION_BITS-1:0] = action;
      word[ACTION_BITS +: VALUE_BITS] = value;
      word[ACTION_BITS + VALUE_BITS +: MULT_BITS] = mult;
      req_tdata <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   function automatic logic [MULT_BITS-1:0] pick_mult();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 2)
         return '0;
      if (roll == 2)
         return '1;
      if (roll < 5)
         return MULT_BITS'($urandom);
      return MULT_BITS'($urandom_range(1, 3));
   endfunction

   function automatic logic [ACTION_BITS-1:0] pick_action();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 8)
         return ACT_INSERT;
      if (roll < 15)
         return ACT_REMOVE;
      if (roll < 19)
         return ACT_QUERY;
      return ACT_SPARE;
   endfunction

   function automatic value_type pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7)
         return value_pool[$urandom_range(0, 7)];
      if (roll < 9)
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return value_type'($urandom);
   endfunction

   // receiver: changing ready patterns, plus one long hold on request
   initial begin
      int mode;
      int mode_left;
      bit hold_done;
      mode = 0;
      mode_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      int random_items;
      int episode;
      int kind;
      int count;
      int start;
      int i;
      value_pool[0] = VALUE_MIN;
      value_pool[1] = VALUE_MAX;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (i = 4; i < POOL_SIZE; i++)
         value_pool[i] = value_type'($urandom);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening
      send_item(ACT_QUERY, '0, 16'd0);
      send_item(ACT_REMOVE, 5, 16'd1);
      send_item(ACT_INSERT, '0, 16'd0);
      send_item(ACT_INSERT, VALUE_MAX, 16'd1);
      send_item(ACT_INSERT, VALUE_MIN, 16'hFFFF);
      send_item(ACT_INSERT, VALUE_MIN, 16'd1);
      send_item(ACT_INSERT, -1, 16'hFFFF);
      send_item(ACT_INSERT, -1, 16'hFFFF);
      send_item(ACT_INSERT, '0, 16'd0);
      send_item(ACT_INSERT, VALUE_MAX, 16'd0);
      send_item(ACT_QUERY, VALUE_MAX, 16'hFFFF);
      send_item(ACT_QUERY, 12345, 16'd0);
      send_item(ACT_SPARE, VALUE_MIN, 16'd0);
      send_item(ACT_SPARE, 777, 16'd0);
      send_item(ACT_REMOVE, VALUE_MAX, 16'd0);
      send_item(ACT_REMOVE, VALUE_MAX, 16'd0);
      send_item(ACT_REMOVE, VALUE_MIN, 16'd0);
      send_item(ACT_INSERT, value_type'(32'h5555_5555), 16'hAAAA);
      send_item(ACT_INSERT, value_type'(32'hAAAA_AAAA), 16'h5555);
      send_item(ACT_REMOVE, value_type'(32'hAAAA_AAAA), 16'd0);
      send_item(ACT_INSERT, 1, 16'd1);
      send_item(ACT_REMOVE, 1, 16'd1);
      send_item(ACT_QUERY, -1, 16'd0);
      wait_drained();

      // random episodes: hot-value mix, table fill, drain
      random_items = 0;
      episode = 0;
      while (random_items < RANDOM_ITEMS) begin
         kind = (episode == 0) ? 6 : $urandom_range(0, 9);
         if (episode == 1)
            kind = 0;
         if (kind < 6) begin
            if (episode == 1)
               hold_rsp = 1'b1;
            count = $urandom_range(20, 60);
            repeat (count) begin
               send_item(pick_action(), pick_value(), pick_mult());
               random_items++;
            end
         end else if (kind < 8) begin
            start = $urandom_range(0, POOL_SIZE - 1);
            for (i = 0; i < POOL_SIZE; i++) begin
               send_item(ACT_INSERT, value_pool[(start + i) % POOL_SIZE],
                         MULT_BITS'($urandom_range(1, 2)));
               random_items++;
            end
         end else begin
            for (i = 0; i < POOL_SIZE; i++) begin
               count = $urandom_range(1, 3);
               repeat (count) begin
                  send_item(ACT_REMOVE, value_pool[i], pick_mult());
                  random_items++;
               end
            end
         end
         if (episode == 0 || $urandom_range(0, 3) == 0)
            wait_drained();
         episode++;
      end

      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("sorted_multiset_table_unit test passed");
      else
         $display("sorted_multiset_table_unit test failed");
      $finish;
   end

endmodule
